// ===== rtl/core/fqs_pkg.sv =====
package fqs_pkg;

   localparam int DEPTH_DEF = 16;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_EMPTY = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] data_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic               found;
      logic [3:0]         distance;
      logic signed [31:0] head_value;
      logic               empty_res;
      logic [4:0]         occupancy;
      logic [1:0]         error_code;
   } rsp_type;

   // per-cell control: shift towards the head, or load the broadcast word
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// ===== rtl/core/fqs_cell.sv =====
module fqs_cell (
   input  logic                 clock,
   input  fqs_pkg::cell_ctl_type ctl,
   input  logic [31:0]          shift_in,
   input  logic [31:0]          bcast,
   output logic [31:0]          value
);

   logic [31:0] value_ff;
   logic [31:0] value_in;

   // load beats shift: the rotating head word lands in the last occupied cell
   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = bcast;
      end else if (ctl.shift) begin
         value_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== rtl/core/fifo_queue_with_search.sv =====
// Queue of signed 32-bit words held in a row of DEPTH shift cells, cell 0 = head.
// Push, pop and unused opcodes: result registered in the cycle after accept;
// 1 word/cycle unless a held result stalls the input. Search: the words rotate
// through cell 0, one per cycle, and the result is registered once all entries
// have passed (at once when empty); the input stalls until the scan ends.
// Synchronous active-high reset empties the queue and drops any pending result;
// cell contents are not reset.
module fifo_queue_with_search #(
   parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fqs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fqs_pkg::rsp_type rsp_data
);

   localparam int CNTW = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // ---- cell row ----
   logic [31:0]           cell_q [DEPTH];
   fqs_pkg::cell_ctl_type cell_ctl [DEPTH];
   logic                  shift_en;
   logic                  load_en;
   logic [CNTW-1:0]       load_idx;
   logic [31:0]           bcast;

   // ---- control registers ----
   logic            state_ff, state_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [CNTW-1:0] scan_ff, scan_in;     // position of the word now in cell 0
   logic [CNTW-1:0] dist_ff, dist_in;
   logic            found_ff, found_in;
   logic [31:0]     key_ff, key_in;
   logic [31:0]     head_ff, head_in;      // head word saved for the search result
   logic            rsp_valid_ff, rsp_valid_in;
   fqs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            rsp_take;
   logic            rsp_load;
   logic            match;
   logic            last_scan;
   logic [CNTW+4:0] occ_ext;
   logic [CNTW+3:0] dist_ext;
   logic [CNTW-1:0] dist_res;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   assign match     = (cell_q[0] == key_ff) && !found_ff;
   assign last_scan = (scan_ff == count_ff - CNTW'(1));

   // one decoder per cell: only the addressed cell takes the broadcast word
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [31:0] right;
      if (i == DEPTH - 1) begin : g_last
         assign right = cell_q[i];
      end else begin : g_mid
         assign right = cell_q[i+1];
      end
      assign cell_ctl[i].shift = shift_en;
      assign cell_ctl[i].load  = load_en && (load_idx == CNTW'(i));
      fqs_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .shift_in (right),
         .bcast    (bcast),
         .value    (cell_q[i])
      );
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      dist_in     = dist_ff;
      found_in    = found_ff;
      key_in      = key_ff;
      head_in     = head_ff;
      shift_en    = 1'b0;
      load_en     = 1'b0;
      load_idx    = count_ff;
      bcast       = req_data.data_value;
      rsp_load    = 1'b0;
      dist_res    = '0;
      rsp_data_in = rsp_data_ff;
      rsp_data_in.popped_value = '0;
      rsp_data_in.found        = 1'b0;
      rsp_data_in.error_code   = fqs_pkg::ERR_OK;
      rsp_data_in.head_value   = (count_ff == '0) ? '0 : cell_q[0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               case (req_data.op)
                  fqs_pkg::OP_PUSH: begin
                     if (count_ff == CNTW'(DEPTH)) begin
                        rsp_data_in.error_code = fqs_pkg::ERR_FULL;
                     end else begin
                        load_en  = 1'b1;
                        count_in = count_ff + CNTW'(1);
                        if (count_ff == '0) begin
                           rsp_data_in.head_value = req_data.data_value;
                        end
                     end
                  end
                  fqs_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_data_in.error_code = fqs_pkg::ERR_EMPTY;
                     end else begin
                        shift_en = 1'b1;
                        count_in = count_ff - CNTW'(1);
                        rsp_data_in.popped_value = cell_q[0];
                        rsp_data_in.head_value   = (count_ff == CNTW'(1)) ? '0 : cell_q[1];
                     end
                  end
                  fqs_pkg::OP_SEARCH: begin
                     // empty queue: nothing to scan, answer at once
                     if (count_ff != '0) begin
                        rsp_load = 1'b0;
                        state_in = ST_SCAN;
                        scan_in  = '0;
                        dist_in  = '0;
                        found_in = 1'b0;
                        key_in   = req_data.data_value;
                        head_in  = cell_q[0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // rotate: every cell shifts, the head word goes to the last occupied cell
            shift_en = 1'b1;
            load_en  = 1'b1;
            load_idx = count_ff - CNTW'(1);
            bcast    = cell_q[0];
            scan_in  = scan_ff + CNTW'(1);
            if (match) begin
               found_in = 1'b1;
               dist_in  = scan_ff;
            end
            if (last_scan) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               rsp_data_in.found      = found_ff || match;
               rsp_data_in.head_value = head_ff;
               dist_res = match ? scan_ff : dist_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // distance and occupancy keep only their low bits for wide queues
      dist_ext = {4'b0, dist_res};
      occ_ext  = {5'b0, count_in};
      rsp_data_in.distance  = dist_ext[3:0];
      rsp_data_in.occupancy = occ_ext[4:0];
      rsp_data_in.empty_res = (count_in == '0);

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         scan_ff      <= '0;
         dist_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         scan_ff      <= scan_in;
         dist_ff      <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      head_ff <= head_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- checks ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(DEPTH))
      else $error("occupancy beyond queue depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff < count_ff))
      else $error("scan position past last entry");

   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("search running while a result is pending");

   a_count_steady: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> $stable(count_ff))
      else $error("occupancy changed during search");

endmodule

// ===== bench/fqs_scoreboard_pkg.sv =====
`timescale 1ns / 100ps

package fqs_scoreboard_pkg;

   class fifo_scoreboard;

      localparam int QDEPTH = fqs_pkg::DEPTH_DEF;

      // shadow of the queue
      logic signed [31:0] shadow_store [QDEPTH];
      int                 head_ptr;
      int                 tail_ptr;
      int                 fill;

      fqs_pkg::rsp_type   outcome_q [$];
      int                 errors;

      function new();
         foreach (shadow_store[i]) shadow_store[i] = '0;
         head_ptr = 0;
         tail_ptr = 0;
         fill     = 0;
         errors   = 0;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      // one line per mismatch
      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h want %h", what, got, want);
         errors++;
      endtask

      // work out the outcome of an accepted request word and queue it
      function void note_request(fqs_pkg::req_type w);
         fqs_pkg::rsp_type e;
         int               idx;
         e = '0;
         case (w.op)
            fqs_pkg::OP_PUSH: begin
               if (fill >= QDEPTH) begin
                  e.error_code = fqs_pkg::ERR_FULL;
               end else begin
                  shadow_store[tail_ptr] = w.data_value;
                  tail_ptr = (tail_ptr + 1) % QDEPTH;
                  fill++;
               end
            end
            fqs_pkg::OP_POP: begin
               if (fill == 0) begin
                  e.error_code = fqs_pkg::ERR_EMPTY;
               end else begin
                  e.popped_value = shadow_store[head_ptr];
                  head_ptr = (head_ptr + 1) % QDEPTH;
                  fill--;
               end
            end
            fqs_pkg::OP_SEARCH: begin
               idx = head_ptr;
               for (int i = 0; i < fill; i++) begin
                  if (!e.found && shadow_store[idx] == w.data_value) begin
                     e.found    = 1'b1;
                     e.distance = i[3:0];
                  end
                  idx = (idx + 1) % QDEPTH;
               end
            end
            default: ;
         endcase
         if (fill != 0)
            e.head_value = shadow_store[head_ptr];
         e.empty_res = (fill == 0);
         e.occupancy = fill[4:0];
         outcome_q.push_back(e);
      endfunction

      task check_response(fqs_pkg::rsp_type got);
         fqs_pkg::rsp_type want;
         if (outcome_q.size() == 0) begin
            report("unexpected result word", got.head_value, '0);
            return;
         end
         want = outcome_q.pop_front();
         if (got.popped_value !== want.popped_value)
            report("popped_value", got.popped_value, want.popped_value);
         if (got.found !== want.found)
            report("found", 32'(got.found), 32'(want.found));
         if (got.distance !== want.distance)
            report("distance", 32'(got.distance), 32'(want.distance));
         if (got.head_value !== want.head_value)
            report("head_value", got.head_value, want.head_value);
         if (got.empty_res !== want.empty_res)
            report("empty_res", 32'(got.empty_res), 32'(want.empty_res));
         if (got.occupancy !== want.occupancy)
            report("occupancy", 32'(got.occupancy), 32'(want.occupancy));
         if (got.error_code !== want.error_code)
            report("error_code", 32'(got.error_code), 32'(want.error_code));
      endtask

   endclass

endpackage

// ===== bench/fifo_queue_with_search_tb.sv =====
`timescale 1ns / 100ps

module fifo_queue_with_search_tb;

   localparam int RANDOM_WORDS = 650;
   localparam int HOLD_AT      = 200;     // result count at which the long hold starts
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 40;      // margin for a search still in its scan
   localparam int CYCLE_LIMIT  = 250000;

   localparam logic [1:0] OP_SPARE = 2'd3;   // unused opcode

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   fqs_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   fqs_pkg::rsp_type rsp_data;

   fqs_scoreboard_pkg::fifo_scoreboard sb = new();
   int                                 cycle_count = 0;

   // small pool of values so that random searches hit often
   logic signed [31:0] value_pool [8];

   fifo_queue_with_search u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // monitor: both channels sampled at the edge; a result is checked before the
   // request word of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
      end
   end

   function automatic fqs_pkg::req_type mk_word(logic [1:0] op, logic signed [31:0] v);
      fqs_pkg::req_type w;
      w.op         = op;
      w.data_value = v;
      return w;
   endfunction

   // offer one word after a gap of idle cycles; returns at its accepting edge.
   // With no gap, valid stays high straight into the next word.
   task automatic send_word(input fqs_pkg::req_type w, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // value for a push: mostly from the pool, sometimes fully random
   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(0, 9) < 7)
         return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // result side: random stall per word, quiet stretches, and one long hold
   // while the sender keeps offering, so the pending result stalls its input
   initial begin
      int  n;
      int  got;
      int  seg;
      bit  quiet;
      got   = 0;
      seg   = 0;
      quiet = 1'b0;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (seg == 0) begin
            seg   = $urandom_range(20, 60);
            quiet = ($urandom_range(0, 3) == 0);
         end
         seg--;
         n = quiet ? 0 : $urandom_range(0, 12);
         if (got == HOLD_AT) n = HOLD_CYCLES;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         got++;
      end
   end

   // request side
   initial begin
      logic signed [31:0] v;
      logic signed [31:0] last_push;
      logic [1:0]         op;
      int                 mode;
      int                 seg;
      int                 roll;
      bit                 quiet;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      value_pool[0] = 32'sh7FFF_FFFF;
      value_pool[1] = 32'sh8000_0000;
      value_pool[2] = '0;
      value_pool[3] = -32'sd1;
      for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: errors on empty, unused opcode, extremes, last pop, full
      send_word(mk_word(fqs_pkg::OP_POP, 32'sh1234_5678), $urandom_range(0, 12));
      send_word(mk_word(fqs_pkg::OP_SEARCH, '0), $urandom_range(0, 12));
      send_word(mk_word(OP_SPARE, -32'sd1), $urandom_range(0, 12));
      send_word(mk_word(fqs_pkg::OP_PUSH, 32'sh7FFF_FFFF), $urandom_range(0, 12));
      send_word(mk_word(fqs_pkg::OP_PUSH, 32'sh8000_0000), $urandom_range(0, 12));
      send_word(mk_word(OP_SPARE, '0), $urandom_range(0, 12));
      send_word(mk_word(fqs_pkg::OP_SEARCH, 32'sh8000_0000), $urandom_range(0, 12));
      send_word(mk_word(fqs_pkg::OP_SEARCH, 32'sh0000_0001), $urandom_range(0, 12));
      send_word(mk_word(fqs_pkg::OP_POP, '0), $urandom_range(0, 12));
      send_word(mk_word(fqs_pkg::OP_POP, '0), $urandom_range(0, 12));   // queue now empty
      last_push = '0;
      for (int k = 0; k < fqs_pkg::DEPTH_DEF; k++) begin
         last_push = (k == 0) ? -32'sd1 : (k == 1) ? 32'sd0 : $urandom;
         send_word(mk_word(fqs_pkg::OP_PUSH, last_push), $urandom_range(0, 3));
      end
      send_word(mk_word(fqs_pkg::OP_PUSH, 32'sh5A5A_5A5A), $urandom_range(0, 12));  // full
      send_word(mk_word(fqs_pkg::OP_SEARCH, last_push), $urandom_range(0, 12));     // far end

      // random: segments leaning to fill, to drain, or balanced, so the queue
      // swings between full and empty with searches throughout
      seg   = 0;
      mode  = 0;
      quiet = 1'b0;
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (seg == 0) begin
            seg   = $urandom_range(30, 60);
            mode  = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 3) == 0);
         end
         seg--;
         roll = $urandom_range(0, 99);
         if (roll < 5)
            op = OP_SPARE;
         else if (roll < 30)
            op = fqs_pkg::OP_SEARCH;
         else if (mode == 0)
            op = (roll < 85) ? fqs_pkg::OP_PUSH : fqs_pkg::OP_POP;
         else if (mode == 1)
            op = (roll < 45) ? fqs_pkg::OP_PUSH : fqs_pkg::OP_POP;
         else
            op = (roll < 65) ? fqs_pkg::OP_PUSH : fqs_pkg::OP_POP;
         v = (op == fqs_pkg::OP_POP || op == OP_SPARE) ? $urandom : pick_value();
         send_word(mk_word(op, v), quiet ? 0 : $urandom_range(0, 12));
      end
      req_valid <= 1'b0;

      // drain, then give any late word time to show up
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
